// ===== rtl/core/atsu_pkg.sv =====
// Shared types, constants and decode functions for the antisymmetric triple unpack unit.
`default_nettype none

package atsu_pkg;

  localparam int unsigned IdxW       = 30;
  localparam int unsigned ValW       = 64;
  localparam int unsigned OccCntW    = 5;
  localparam int unsigned VirCntW    = 7;
  localparam int unsigned CfgDataW   = 7;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned NumPerm    = 6;
  localparam int unsigned PermW      = 3;
  localparam int unsigned StepW      = 5;
  localparam int unsigned VoffBase   = 2;
  localparam int unsigned OtermBase  = VoffBase + 2 * NumPerm;
  localparam int unsigned SetupSteps = OtermBase + 3 * NumPerm;
  localparam int unsigned MaxOccDef  = 16;
  localparam int unsigned MaxVirDef  = 64;
  localparam int unsigned OccCntRst  = 16;
  localparam int unsigned VirCntRst  = 64;
  localparam int unsigned MinCount   = 3;

  localparam logic [PermW-1:0] LastPerm     = PermW'(NumPerm - 1);
  localparam logic [PermW-1:0] FirstOddPerm = PermW'(3);

  // Permutation order: three even rotations, then three odd swaps.
  localparam logic [1:0] PermTab [NumPerm][3] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd1, 2'd0, 2'd2},
    '{2'd0, 2'd2, 2'd1},
    '{2'd2, 2'd1, 2'd0}
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OCC_COUNT = 1'b0,
    CFG_VIR_COUNT = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OPD_ZERO,
    OPD_ACC,
    OPD_NV,
    OPD_OCC,
    OPD_VIR
  } opd_e;

  typedef enum logic [1:0] {
    MUL_NO,
    MUL_NV,
    MUL_NV3
  } mul_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_NV3,
    DST_VOFF,
    DST_OTERM
  } dst_e;

  // One multiply-add step: acc <= a * mul + c, with an optional table write.
  typedef struct packed {
    opd_e             a_src;
    logic [1:0]       a_pos;
    mul_e             mul_src;
    opd_e             c_src;
    logic [1:0]       c_pos;
    dst_e             dst;
    logic [PermW-1:0] slot;
  } uop_t;

  typedef struct packed {
    logic             take;
    logic             mac_en;
    logic [StepW-1:0] step;
    logic             load;
    logic [PermW-1:0] load_p;
    logic [PermW-1:0] load_q;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_ok;
  } dp_stat_t;

  function automatic logic [1:0] perm_at(input logic [PermW-1:0] p, input logic [1:0] pos);
    logic [1:0] r;
    r = 2'd0;
    if (p <= LastPerm && pos <= 2'd2) begin
      r = PermTab[p][pos];
    end
    return r;
  endfunction

  // Setup schedule:
  //   step 0,1   : nv^2, nv^3
  //   two steps  : virtual offset of each permutation
  //   three steps: occupied offset of each permutation, scaled by nv^3
  function automatic uop_t uop_at(input logic [StepW-1:0] step);
    uop_t               u;
    logic [StepW-1:0]   k;
    logic [StepW+3:0]   k11;
    logic [PermW-1:0]   s;
    logic [1:0]         ph;
    u.a_src   = OPD_ACC;
    u.a_pos   = 2'd0;
    u.mul_src = MUL_NV;
    u.c_src   = OPD_ZERO;
    u.c_pos   = 2'd0;
    u.dst     = DST_NONE;
    u.slot    = '0;
    k         = '0;
    k11       = '0;
    s         = '0;
    ph        = '0;
    if (step == StepW'(0)) begin
      u.a_src = OPD_NV;
    end else if (step == StepW'(1)) begin
      u.dst = DST_NV3;
    end else if (step < StepW'(OtermBase)) begin
      k      = step - StepW'(VoffBase);
      s      = k[3:1];
      u.slot = s;
      if (!k[0]) begin
        u.a_src = OPD_VIR;
        u.a_pos = perm_at(s, 2'd0);
        u.c_src = OPD_VIR;
        u.c_pos = perm_at(s, 2'd1);
      end else begin
        u.c_src = OPD_VIR;
        u.c_pos = perm_at(s, 2'd2);
        u.dst   = DST_VOFF;
      end
    end else begin
      k      = step - StepW'(OtermBase);
      // k / 3 for k below 18
      k11    = (StepW + 4)'(k) * (StepW + 4)'(11);
      s      = PermW'(k11 >> 5);
      ph     = 2'(k - StepW'(s) - StepW'({s, 1'b0}));
      u.slot = s;
      u.mul_src = MUL_NO;
      case (ph)
        2'd0: begin
          u.a_src = OPD_OCC;
          u.a_pos = perm_at(s, 2'd0);
          u.c_src = OPD_OCC;
          u.c_pos = perm_at(s, 2'd1);
        end
        2'd1: begin
          u.c_src = OPD_OCC;
          u.c_pos = perm_at(s, 2'd2);
        end
        default: begin
          u.mul_src = MUL_NV3;
          u.dst     = DST_OTERM;
        end
      endcase
    end
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atsu_if.sv =====
// Word channel interfaces: packed amplitude in, scatter write out.
`default_nettype none

interface atsu_in_if;
  logic                       valid;
  logic                       ready;
  logic [atsu_pkg::ValW-1:0]  value_real;
  logic [atsu_pkg::ValW-1:0]  value_imag;

  modport source (output valid, output value_real, output value_imag, input ready);
  modport sink   (input valid, input value_real, input value_imag, output ready);
endinterface

interface atsu_out_if;
  logic                       valid;
  logic                       ready;
  logic [atsu_pkg::IdxW-1:0]  full_index;
  logic [atsu_pkg::ValW-1:0]  out_real;
  logic [atsu_pkg::ValW-1:0]  out_imag;
  logic                       run_last;
  logic                       tensor_last;

  modport source (output valid, output full_index, output out_real, output out_imag,
                  output run_last, output tensor_last, input ready);
  modport sink   (input valid, input full_index, input out_real, input out_imag,
                  input run_last, input tensor_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/atsu_adv.sv =====
// Ascending index triple advance with wrap to (0,1,2).
`default_nettype none

module atsu_adv #(
  parameter int unsigned W = $clog2(atsu_pkg::MaxOccDef)
) (
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  input  wire logic [W-1:0] z_i,
  input  wire logic [W:0]   n_i,
  output logic      [W-1:0] x_o,
  output logic      [W-1:0] y_o,
  output logic      [W-1:0] z_o,
  output logic              wrap_o
);

  logic [W:0] xe, ye, ze;

  assign xe = {1'b0, x_i};
  assign ye = {1'b0, y_i};
  assign ze = {1'b0, z_i};

  always_comb begin
    x_o    = x_i;
    y_o    = y_i;
    z_o    = z_i;
    wrap_o = 1'b0;
    if (ze + (W + 1)'(1) < n_i) begin
      z_o = z_i + W'(1);
    end else if (ye + (W + 1)'(2) < n_i) begin
      y_o = y_i + W'(1);
      z_o = y_i + W'(2);
    end else if (xe + (W + 1)'(3) < n_i) begin
      x_o = x_i + W'(1);
      y_o = x_i + W'(2);
      z_o = x_i + W'(3);
    end else begin
      x_o    = W'(0);
      y_o    = W'(1);
      z_o    = W'(2);
      wrap_o = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/atsu_datapath.sv =====
// Datapath: count registers, running indices, shared multiply-add, offset tables, output word.
`default_nettype none

module atsu_datapath #(
  parameter int unsigned MAX_OCC = atsu_pkg::MaxOccDef,
  parameter int unsigned MAX_VIR = atsu_pkg::MaxVirDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [atsu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [atsu_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic [atsu_pkg::ValW-1:0]     value_real_i,
  input  wire logic [atsu_pkg::ValW-1:0]     value_imag_i,
  input  wire atsu_pkg::dp_cmd_t             cmd_i,
  output atsu_pkg::dp_stat_t                 stat_o,
  output logic      [atsu_pkg::IdxW-1:0]     full_index_o,
  output logic      [atsu_pkg::ValW-1:0]     out_real_o,
  output logic      [atsu_pkg::ValW-1:0]     out_imag_o,
  output logic                               run_last_o,
  output logic                               tensor_last_o
);

  localparam int unsigned OccW = $clog2(MAX_OCC);
  localparam int unsigned VirW = $clog2(MAX_VIR);
  localparam int unsigned IW   = atsu_pkg::IdxW;
  localparam int unsigned VW   = atsu_pkg::ValW;

  function automatic logic [IW-1:0] pick3(input logic [1:0] pos, input logic [IW-1:0] e0,
                                          input logic [IW-1:0] e1, input logic [IW-1:0] e2);
    logic [IW-1:0] r;
    case (pos)
      2'd0:    r = e0;
      2'd1:    r = e1;
      default: r = e2;
    endcase
    return r;
  endfunction

  logic [atsu_pkg::OccCntW-1:0] occ_cnt_q;
  logic [atsu_pkg::VirCntW-1:0] vir_cnt_q;
  logic [OccW:0]                n_occ;
  logic [VirW:0]                n_vir;

  logic [OccW-1:0] occ_x_q, occ_y_q, occ_z_q, occ_x_d, occ_y_d, occ_z_d;
  logic [VirW-1:0] vir_x_q, vir_y_q, vir_z_q, vir_x_d, vir_y_d, vir_z_d;
  logic            occ_wrap, vir_wrap;

  logic [OccW-1:0] wo0_q, wo1_q, wo2_q;
  logic [VirW-1:0] wv0_q, wv1_q, wv2_q;
  logic [VW-1:0]   val_real_q, val_imag_q;
  logic            tl_q;

  logic [IW-1:0]   acc_q, nv3_q;
  logic [IW-1:0]   voff_q [atsu_pkg::NumPerm];
  logic [IW-1:0]   oterm_q [atsu_pkg::NumPerm];

  atsu_pkg::uop_t  uop;
  logic [IW-1:0]   occ_a, occ_c, vir_a, vir_c;
  logic [IW-1:0]   a_val, b_val, c_val, mac_res;
  logic [IW-1:0]   prod;

  logic [IW-1:0]   word_idx;
  logic            word_odd;

  logic [IW-1:0]   out_idx_q;
  logic [VW-1:0]   out_real_q, out_imag_q;
  logic            run_last_q, tlast_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_cnt_q <= atsu_pkg::OccCntW'(atsu_pkg::OccCntRst);
      vir_cnt_q <= atsu_pkg::VirCntW'(atsu_pkg::VirCntRst);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == atsu_pkg::CFG_OCC_COUNT) begin
        occ_cnt_q <= cfg_data_i[atsu_pkg::OccCntW-1:0];
      end else begin
        vir_cnt_q <= cfg_data_i[atsu_pkg::VirCntW-1:0];
      end
    end
  end

  // Saturate counts to the index range
  assign n_occ = (32'(occ_cnt_q) > MAX_OCC) ? (OccW + 1)'(MAX_OCC) : (OccW + 1)'(occ_cnt_q);
  assign n_vir = (32'(vir_cnt_q) > MAX_VIR) ? (VirW + 1)'(MAX_VIR) : (VirW + 1)'(vir_cnt_q);

  assign stat_o.cfg_ok = (n_occ >= (OccW + 1)'(atsu_pkg::MinCount)) &&
                         (n_vir >= (VirW + 1)'(atsu_pkg::MinCount));

  atsu_adv #(.W(OccW)) u_occ_adv (
    .x_i    (occ_x_q),
    .y_i    (occ_y_q),
    .z_i    (occ_z_q),
    .n_i    (n_occ),
    .x_o    (occ_x_d),
    .y_o    (occ_y_d),
    .z_o    (occ_z_d),
    .wrap_o (occ_wrap)
  );

  atsu_adv #(.W(VirW)) u_vir_adv (
    .x_i    (vir_x_q),
    .y_i    (vir_y_q),
    .z_i    (vir_z_q),
    .n_i    (n_vir),
    .x_o    (vir_x_d),
    .y_o    (vir_y_d),
    .z_o    (vir_z_d),
    .wrap_o (vir_wrap)
  );

  // Running indices: virtual triple is the fast one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_x_q <= OccW'(0);
      occ_y_q <= OccW'(1);
      occ_z_q <= OccW'(2);
      vir_x_q <= VirW'(0);
      vir_y_q <= VirW'(1);
      vir_z_q <= VirW'(2);
    end else if (cmd_i.take) begin
      vir_x_q <= vir_x_d;
      vir_y_q <= vir_y_d;
      vir_z_q <= vir_z_d;
      if (vir_wrap) begin
        occ_x_q <= occ_x_d;
        occ_y_q <= occ_y_d;
        occ_z_q <= occ_z_d;
      end
    end
  end

  // Working copy of the item
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      wo0_q      <= occ_x_q;
      wo1_q      <= occ_y_q;
      wo2_q      <= occ_z_q;
      wv0_q      <= vir_x_q;
      wv1_q      <= vir_y_q;
      wv2_q      <= vir_z_q;
      val_real_q <= value_real_i;
      val_imag_q <= value_imag_i;
      tl_q       <= vir_wrap & occ_wrap;
    end
  end

  // Shared multiply-add
  assign uop   = atsu_pkg::uop_at(cmd_i.step);
  assign occ_a = pick3(uop.a_pos, IW'(wo0_q), IW'(wo1_q), IW'(wo2_q));
  assign occ_c = pick3(uop.c_pos, IW'(wo0_q), IW'(wo1_q), IW'(wo2_q));
  assign vir_a = pick3(uop.a_pos, IW'(wv0_q), IW'(wv1_q), IW'(wv2_q));
  assign vir_c = pick3(uop.c_pos, IW'(wv0_q), IW'(wv1_q), IW'(wv2_q));

  always_comb begin
    case (uop.a_src)
      atsu_pkg::OPD_ACC: a_val = acc_q;
      atsu_pkg::OPD_NV:  a_val = IW'(n_vir);
      atsu_pkg::OPD_OCC: a_val = occ_a;
      atsu_pkg::OPD_VIR: a_val = vir_a;
      default:           a_val = '0;
    endcase
    case (uop.c_src)
      atsu_pkg::OPD_OCC: c_val = occ_c;
      atsu_pkg::OPD_VIR: c_val = vir_c;
      default:           c_val = '0;
    endcase
    case (uop.mul_src)
      atsu_pkg::MUL_NO:  b_val = IW'(n_occ);
      atsu_pkg::MUL_NV:  b_val = IW'(n_vir);
      atsu_pkg::MUL_NV3: b_val = nv3_q;
      default:           b_val = '0;
    endcase
  end

  // Only the low 30 bits of the product are ever needed
  assign prod    = a_val * b_val;
  assign mac_res = prod + c_val;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_en) begin
      acc_q <= mac_res;
      case (uop.dst)
        atsu_pkg::DST_NV3:   nv3_q <= mac_res;
        atsu_pkg::DST_VOFF:  voff_q[uop.slot] <= mac_res;
        atsu_pkg::DST_OTERM: oterm_q[uop.slot] <= mac_res;
        default: ;
      endcase
    end
  end

  // Output word
  assign word_idx = oterm_q[cmd_i.load_p] + voff_q[cmd_i.load_q];
  assign word_odd = (cmd_i.load_p >= atsu_pkg::FirstOddPerm) ^
                    (cmd_i.load_q >= atsu_pkg::FirstOddPerm);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_idx_q  <= word_idx;
      out_real_q <= val_real_q ^ {word_odd, {(VW - 1){1'b0}}};
      out_imag_q <= val_imag_q ^ {word_odd, {(VW - 1){1'b0}}};
      run_last_q <= (cmd_i.load_p == atsu_pkg::LastPerm) &&
                    (cmd_i.load_q == atsu_pkg::LastPerm);
      tlast_q    <= tl_q;
    end
  end

  assign full_index_o  = out_idx_q;
  assign out_real_o    = out_real_q;
  assign out_imag_o    = out_imag_q;
  assign run_last_o    = run_last_q;
  assign tensor_last_o = tlast_q;

endmodule

`default_nettype wire

// ===== rtl/core/atsu_ctrl.sv =====
// Controller: item accept, setup schedule, 36-word emit sequence.
`default_nettype none

module atsu_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire atsu_pkg::dp_stat_t stat_i,
  output atsu_pkg::dp_cmd_t       cmd_o
);

  localparam int unsigned SW = atsu_pkg::StepW;
  localparam int unsigned PW = atsu_pkg::PermW;

  atsu_pkg::state_e state_q, state_d;
  logic [SW-1:0]    step_q, step_d;
  logic [PW-1:0]    p_q, p_d, q_q, q_d;
  logic             last_word;
  logic             setup_done;

  assign last_word  = (p_q == atsu_pkg::LastPerm) && (q_q == atsu_pkg::LastPerm);
  assign setup_done = (step_q == SW'(atsu_pkg::SetupSteps - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      atsu_pkg::ST_IDLE: begin
        if (in_valid_i && stat_i.cfg_ok) state_d = atsu_pkg::ST_SETUP;
      end
      atsu_pkg::ST_SETUP: begin
        if (setup_done) state_d = atsu_pkg::ST_FILL;
      end
      atsu_pkg::ST_FILL: begin
        state_d = atsu_pkg::ST_EMIT;
      end
      atsu_pkg::ST_EMIT: begin
        if (out_ready_i && last_word) state_d = atsu_pkg::ST_IDLE;
      end
      default: state_d = atsu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    cmd_o         = '0;
    cmd_o.step    = step_q;
    step_d        = step_q;
    p_d           = p_q;
    q_d           = q_q;
    case (state_q)
      atsu_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.take = in_valid_i && stat_i.cfg_ok;
        step_d     = '0;
      end
      atsu_pkg::ST_SETUP: begin
        cmd_o.mac_en = 1'b1;
        step_d       = step_q + SW'(1);
      end
      atsu_pkg::ST_FILL: begin
        cmd_o.load = 1'b1;
        p_d        = '0;
        q_d        = '0;
      end
      atsu_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i && !last_word) begin
          if (q_q == atsu_pkg::LastPerm) begin
            q_d = '0;
            p_d = p_q + PW'(1);
          end else begin
            q_d = q_q + PW'(1);
          end
          cmd_o.load = 1'b1;
        end
      end
      default: ;
    endcase
    cmd_o.load_p = p_d;
    cmd_o.load_q = q_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atsu_pkg::ST_IDLE;
      step_q  <= '0;
      p_q     <= '0;
      q_q     <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      p_q     <= p_d;
      q_q     <= q_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/antisym_triple_unpack_scatter_unit.sv =====
// Top level: rank-6 antisymmetric tensor unpack into 36 scatter-write words per amplitude.
//
//  channel  dir  handshake        payload
//  in_i     in   valid/ready      value_real[63:0], value_imag[63:0]
//  out_o    out  valid/ready      full_index[29:0], out_real, out_imag, run_last,
//                                 tensor_last
//  cfg      in   cfg_we_i (write) cfg_idx_i (0 occupied count, 1 virtual count),
//                                 cfg_data_i[6:0]
//
// Sequence: per item, an accept, then 32 steps on the single shared 30x30 multiply-add
//   (nv^2, nv^3, six virtual offsets, six occupied offsets scaled by nv^3), a load of
//   the first word, then 36 words at one per cycle while out_o is not stalled. An item
//   taken while either count is below three emits nothing.
// Reset: rst_ni clears the controller and sets the indices to (0,1,2), the counts to 16/64.
// Stalls: out_o ready low holds the current word; in_i ready is high only between items.
`default_nettype none

module antisym_triple_unpack_scatter_unit #(
  parameter int unsigned MAX_OCC = atsu_pkg::MaxOccDef,
  parameter int unsigned MAX_VIR = atsu_pkg::MaxVirDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  atsu_in_if.sink                            in_i,
  atsu_out_if.source                         out_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [atsu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [atsu_pkg::CfgDataW-1:0] cfg_data_i
);

  atsu_pkg::dp_cmd_t  cmd;
  atsu_pkg::dp_stat_t stat;

  // Sequencer: owns the setup step counter and the (p, q) word counters
  atsu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: full_index = occ_offset(p) * nv^3 + vir_offset(q), low 30 bits;
  // sign bit toggled when exactly one of p, q is an odd permutation.
  atsu_datapath #(
    .MAX_OCC (MAX_OCC),
    .MAX_VIR (MAX_VIR)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .value_real_i  (in_i.value_real),
    .value_imag_i  (in_i.value_imag),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .full_index_o  (out_o.full_index),
    .out_real_o    (out_o.out_real),
    .out_imag_o    (out_o.out_imag),
    .run_last_o    (out_o.run_last),
    .tensor_last_o (out_o.tensor_last)
  );

  // One item at a time: no new word taken while results are pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while a word is pending");

  // Words of one item come back to back once the consumer takes them
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.run_last) |=> out_o.valid)
    else $error("word run broken before run_last");

  // The last word of a run returns the block to accepting input
  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.run_last) |=> (in_i.ready && !out_o.valid))
    else $error("block not idle after run_last");

  // tensor_last is a per-item flag, constant over the run
  a_tlast_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.run_last) |=> $stable(out_o.tensor_last))
    else $error("tensor_last changed within a run");

endmodule

`default_nettype wire

// ===== verif/tb_antisym_triple_unpack_scatter_unit.sv =====
// Testbench for the rank-6 antisymmetric unpack unit: directed table, then randomized phases.
`timescale 1ns / 1ps

module tb_antisym_triple_unpack_scatter_unit;
  import atsu_pkg::*;

  // Pause after the last expected word before touching config or ending:
  // one full item plus margin covers an ignored item still in flight.
  localparam int DrainCycles = 80;
  localparam int NumAmps     = 410;
  localparam int MaxPrints   = 100;

  // Permutation order; rows 3..5 are the odd swaps.
  localparam int PermOrder [6][3] = '{
    '{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}, '{1, 0, 2}, '{0, 2, 1}, '{2, 1, 0}
  };
  localparam logic [63:0] SignBit = 64'h8000_0000_0000_0000;

  // Ascending index triple, t[0] < t[1] < t[2].
  typedef logic [2:0][7:0] triple_t;
  localparam triple_t FirstTriple = {8'd2, 8'd1, 8'd0};

  typedef struct {
    logic [IdxW-1:0] full_index;
    logic [ValW-1:0] out_real;
    logic [ValW-1:0] out_imag;
    logic            run_last;
    logic            tensor_last;
  } scatter_word_t;

  typedef enum logic {ROW_AMP, ROW_REG} row_kind_e;

  // One row of the directed table. A pinned row carries the hand-computed
  // full_index / tensor_last of its first word; the rest come from the predictor.
  typedef struct {
    row_kind_e       kind;
    cfg_reg_e        reg_sel;
    logic [6:0]      reg_data;
    logic [ValW-1:0] re;
    logic [ValW-1:0] im;
    bit              pinned;
    logic [IdxW-1:0] pin_idx;
    bit              pin_last;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cfg_reg_e cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  atsu_in_if  amp_if ();
  atsu_out_if wr_if ();

  antisym_triple_unpack_scatter_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (amp_if),
    .out_o      (wr_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: register values and running index triples.
  logic [OccCntW-1:0] occ_count;
  logic [VirCntW-1:0] vir_count;
  triple_t            occ_pos;
  triple_t            vir_pos;

  scatter_word_t pending_writes [$];
  scatter_word_t head_word;
  row_t          plan [$];
  int            err_count = 0;
  int            amps_scattered = 0;
  bit            tx_calm = 1'b0;  // sender: no gaps while set
  bit            rx_calm = 1'b0;  // receiver: no stalls while set

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (err_count < MaxPrints) begin
      $display("%0t mismatch %s: got %h, want %h", $time, field, got, want);
    end
    err_count++;
  endtask

  // Step to the next ascending triple below n; wrapped is set on carry.
  function automatic triple_t next_triple(triple_t t, longint unsigned n, output bit wrapped);
    wrapped = 1'b0;
    if (t[2] + 1 < n) begin
      t[2] = t[2] + 8'd1;
    end else if (t[1] + 2 < n) begin
      t[1] = t[1] + 8'd1;
      t[2] = t[1] + 8'd1;
    end else if (t[0] + 3 < n) begin
      t[0] = t[0] + 8'd1;
      t[1] = t[0] + 8'd1;
      t[2] = t[0] + 8'd2;
    end else begin
      t       = FirstTriple;
      wrapped = 1'b1;
    end
    return t;
  endfunction

  // Queues the 36 scatter words of one amplitude, or none if a count is below three; returns how many.
  function automatic int predict_scatter(logic [ValW-1:0] re, logic [ValW-1:0] im);
    longint unsigned no, nv, ooff, idx;
    triple_t         o_now, v_now;
    bit              vwrap, tensor_wrap;
    logic [63:0]     flip;
    scatter_word_t   w;
    int              n;
    no = (occ_count > MaxOccDef) ? MaxOccDef : occ_count;
    nv = (vir_count > MaxVirDef) ? MaxVirDef : vir_count;
    // too few orbitals: nothing unique, item dropped, state untouched
    if (no < MinCount || nv < MinCount) return 0;
    o_now       = occ_pos;
    v_now       = vir_pos;
    tensor_wrap = 1'b0;
    vir_pos     = next_triple(vir_pos, nv, vwrap);
    if (vwrap) occ_pos = next_triple(occ_pos, no, tensor_wrap);
    n = 0;
    for (int p = 0; p < 6; p++) begin
      ooff = (longint'(o_now[PermOrder[p][0]]) * no + o_now[PermOrder[p][1]]) * no
             + o_now[PermOrder[p][2]];
      for (int q = 0; q < 6; q++) begin
        idx = ((ooff * nv + v_now[PermOrder[q][0]]) * nv + v_now[PermOrder[q][1]]) * nv
              + v_now[PermOrder[q][2]];
        flip          = ((p >= 3) != (q >= 3)) ? SignBit : 64'h0;
        w.full_index  = idx[IdxW-1:0];
        w.out_real    = re ^ flip;
        w.out_imag    = im ^ flip;
        w.run_last    = (n == 35);
        w.tensor_last = tensor_wrap;
        pending_writes.push_back(w);
        n++;
      end
    end
    return n;
  endfunction

  function automatic logic [ValW-1:0] random_double();
    case ($urandom_range(0, 9))
      0:       return 64'h0000_0000_0000_0000;
      1:       return 64'h8000_0000_0000_0000;  // -0
      2:       return 64'h7FF0_0000_0000_0000;  // +inf
      3:       return 64'hFFF8_0000_0000_0001;  // NaN, sign set
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void add_amp(logic [ValW-1:0] re, logic [ValW-1:0] im);
    row_t r;
    r = '{kind: ROW_AMP, reg_sel: CFG_OCC_COUNT, reg_data: '0, re: re, im: im,
          pinned: 1'b0, pin_idx: '0, pin_last: 1'b0};
    plan.push_back(r);
  endfunction

  function automatic void add_pin(logic [ValW-1:0] re, logic [ValW-1:0] im,
                                  logic [IdxW-1:0] idx, bit last);
    row_t r;
    r = '{kind: ROW_AMP, reg_sel: CFG_OCC_COUNT, reg_data: '0, re: re, im: im,
          pinned: 1'b1, pin_idx: idx, pin_last: last};
    plan.push_back(r);
  endfunction

  function automatic void add_reg(cfg_reg_e sel, logic [6:0] data);
    row_t r;
    r = '{kind: ROW_REG, reg_sel: sel, reg_data: data, re: '0, im: '0,
          pinned: 1'b0, pin_idx: '0, pin_last: 1'b0};
    plan.push_back(r);
  endfunction

  // Offer one amplitude, predict its words once the block takes it.
  task automatic send_amplitude(logic [ValW-1:0] re, logic [ValW-1:0] im, bit pinned,
                                logic [IdxW-1:0] pin_idx, bit pin_last);
    int gap, base, n;
    gap = tx_calm ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      amp_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    amp_if.valid      <= 1'b1;
    amp_if.value_real <= re;
    amp_if.value_imag <= im;
    do @(posedge clk_i); while (!amp_if.ready);
    // valid stays up; settle() or a gap in the next call lowers it
    base = pending_writes.size();
    n    = predict_scatter(re, im);
    if (n != 0) begin
      amps_scattered++;
      if (pinned) begin
        pending_writes[base].full_index  = pin_idx;
        pending_writes[base].tensor_last = pin_last;
      end
    end
  endtask

  // Stop offering, wait for every expected word, then let an ignored item drain.
  task automatic settle();
    amp_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_count(cfg_reg_e sel, logic [6:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= sel;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (sel == CFG_OCC_COUNT) occ_count = data[OccCntW-1:0];
    else vir_count = data;
    @(posedge clk_i);
  endtask

  // Receiver: after each word taken, hold ready low for a random count.
  initial begin : write_sink
    int hold;
    hold = 0;
    wr_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (wr_if.ready) begin
        if (wr_if.valid) begin
          hold = rx_calm ? 0 : $urandom_range(0, 19);
          if (hold != 0) wr_if.ready <= 1'b0;
        end
      end else if (hold <= 1) begin
        wr_if.ready <= 1'b1;
        hold = 0;
      end else begin
        hold--;
      end
    end
  end

  // Scoreboard: every word taken is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && wr_if.valid && wr_if.ready) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected word, full_index", 64'(wr_if.full_index), 64'h0);
      end else begin
        head_word = pending_writes.pop_front();
        if (wr_if.full_index !== head_word.full_index)
          report_mismatch("full_index", 64'(wr_if.full_index), 64'(head_word.full_index));
        if (wr_if.out_real !== head_word.out_real)
          report_mismatch("out_real", wr_if.out_real, head_word.out_real);
        if (wr_if.out_imag !== head_word.out_imag)
          report_mismatch("out_imag", wr_if.out_imag, head_word.out_imag);
        if (wr_if.run_last !== head_word.run_last)
          report_mismatch("run_last", 64'(wr_if.run_last), 64'(head_word.run_last));
        if (wr_if.tensor_last !== head_word.tensor_last)
          report_mismatch("tensor_last", 64'(wr_if.tensor_last), 64'(head_word.tensor_last));
      end
    end
  end

  initial begin : stimulus
    int pick, len;
    rst_ni            <= 1'b0;
    amp_if.valid      <= 1'b0;
    amp_if.value_real <= '0;
    amp_if.value_imag <= '0;
    cfg_we_i          <= 1'b0;
    cfg_idx_i         <= CFG_OCC_COUNT;
    cfg_data_i        <= '0;
    occ_count = OccCntRst;
    vir_count = VirCntRst;
    occ_pos   = FirstTriple;
    vir_pos   = FirstTriple;

    // Reset counts 16/64, indices (0,1,2)/(0,1,2): first word is
    // ((1*16+2)*64^3) + 1*64 + 2.
    add_pin(64'h0, 64'h0, 30'd4718658, 1'b0);
    add_amp(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    add_amp(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    add_amp(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    // Shrink to the minimum mid-stream: virtual triple sits at (0,1,6), past
    // the new range. Index uses it as is, then both triples wrap.
    add_reg(CFG_OCC_COUNT, 7'd3);
    add_reg(CFG_VIR_COUNT, 7'd3);
    add_pin(64'h3FF0_0000_0000_0000, 64'hBFF0_0000_0000_0000, 30'd144, 1'b1);
    // 3x3 tensor has a single unique element: every item ends the tensor
    add_pin(64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0000, 30'd140, 1'b1);
    add_amp(64'h0000_0000_0000_0001, 64'h0);
    // Over-range counts saturate to 16/64
    add_reg(CFG_OCC_COUNT, 7'd31);
    add_reg(CFG_VIR_COUNT, 7'd127);
    add_pin(64'h7FF0_0000_0000_0000, 64'h8000_0000_0000_0000, 30'd4718658, 1'b0);
    add_amp(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
    // Below three: items swallowed, no words, indices kept
    add_reg(CFG_OCC_COUNT, 7'd2);
    add_amp(64'hDEAD_BEEF_0000_0001, 64'h1);
    add_amp(64'h2, 64'h3);
    add_reg(CFG_OCC_COUNT, 7'd0);
    add_reg(CFG_VIR_COUNT, 7'd2);
    add_amp(64'h4, 64'h5);
    // 4x3: four unique elements, carry walks the occupied triple
    add_reg(CFG_OCC_COUNT, 7'd4);
    add_reg(CFG_VIR_COUNT, 7'd3);
    add_amp(64'h4009_21FB_5444_2D18, 64'hC009_21FB_5444_2D18);
    add_amp(64'h0010_0000_0000_0000, 64'h800F_FFFF_FFFF_FFFF);
    add_amp(64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF);
    add_amp(64'h1111_2222_3333_4444, 64'h5555_6666_7777_8888);
    add_amp(64'h9999_AAAA_BBBB_CCCC, 64'hDDDD_EEEE_FFFF_0000);
    // Upper data bits above the occupied field are dropped: 0x63 -> 3
    add_reg(CFG_OCC_COUNT, 7'h63);
    add_reg(CFG_VIR_COUNT, 7'd4);
    add_amp(64'hAAAA_5555_AAAA_5555, 64'h5555_AAAA_5555_AAAA);
    add_amp(64'h0F0F_0F0F_0F0F_0F0F, 64'hF0F0_F0F0_F0F0_F0F0);
    add_amp(64'h3333_CCCC_3333_CCCC, 64'hCCCC_3333_CCCC_3333);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle();
        write_count(plan[i].reg_sel, plan[i].reg_data);
      end else begin
        send_amplitude(plan[i].re, plan[i].im, plan[i].pinned, plan[i].pin_idx,
                       plan[i].pin_last);
      end
    end

    // Random phases. Mostly small counts so tensors wrap often; some full
    // size, some raw 7-bit data (saturation, masking, below three), and some
    // that move one count only while the indices run on.
    while (amps_scattered < NumAmps) begin
      settle();
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        write_count(CFG_OCC_COUNT, 7'd16);
        write_count(CFG_VIR_COUNT, 7'd64);
      end else if (pick == 1) begin
        write_count(CFG_OCC_COUNT, 7'($urandom_range(0, 127)));
        write_count(CFG_VIR_COUNT, 7'($urandom_range(0, 127)));
      end else if (pick == 2) begin
        write_count(CFG_OCC_COUNT, 7'($urandom_range(0, 2)));
      end else if (pick < 6) begin
        if ($urandom_range(0, 1)) write_count(CFG_OCC_COUNT, 7'($urandom_range(3, 16)));
        else write_count(CFG_VIR_COUNT, 7'($urandom_range(3, 64)));
      end else begin
        write_count(CFG_OCC_COUNT, 7'($urandom_range(3, 6)));
        write_count(CFG_VIR_COUNT, 7'($urandom_range(3, 7)));
      end
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      len     = $urandom_range(3, 20);
      repeat (len) send_amplitude(random_double(), random_double(), 1'b0, '0, 1'b0);
    end

    settle();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Allow several times the slowest run before failing.
  initial begin : watchdog
    #15_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
